/* rtl/core/dps_pkg.sv */
// Shared constants and state type for the divisor power sum block.
package dps_pkg;
	localparam int NUMBER_WIDTH_DEF = 16;
	localparam int NUMBER_BITS      = 16;
	localparam int EXPONENT_BITS    = 6;
	localparam int TOTAL_BITS       = 64;
	localparam int COUNT_BITS       = 5;
	localparam logic [TOTAL_BITS-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_POW,
		ST_MUL_WAIT,
		ST_ADD,
		ST_OUT
	} state_t;
endpackage

/* rtl/core/dps_if.sv */
// Channel interfaces for operand words and result words.
interface dps_op_if;
	logic                                      valid;
	logic                                      ready;
	logic        [dps_pkg::NUMBER_BITS-1:0]    number;
	logic signed [dps_pkg::EXPONENT_BITS-1:0]  exponent;
	modport source (output valid, output number, output exponent, input ready);
	modport sink (input valid, input number, input exponent, output ready);
endinterface

interface dps_res_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dps_pkg::TOTAL_BITS-1:0]  total;
	logic                                   invalid;
	logic                                   overflow;
	modport source (output valid, output total, output invalid, output overflow, input ready);
	modport sink (input valid, input total, input invalid, input overflow, output ready);
endinterface

/* rtl/core/dps_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module dps_divider #(
	parameter int NW = dps_pkg::NUMBER_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient,
	output logic [NW-1:0] remainder
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic          fits;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// load on start, then step once per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? NW'(trial - {1'b0, dvs_q}) : trial[NW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

/* rtl/core/dps_multiplier.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module dps_multiplier #(
	parameter int NW = dps_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [dps_pkg::TOTAL_BITS-1:0]  a,
	input  logic [NW-1:0]                   b,
	output logic                            done,
	output logic [dps_pkg::TOTAL_BITS-1:0]  product,
	output logic                            sat
);
	localparam int TB = dps_pkg::TOTAL_BITS;
	localparam int PW = TB + NW;
	localparam int CW = $clog2(NW + 1);

	logic [PW-1:0] acc_q;
	logic [PW-1:0] mcand_q;
	logic [NW-1:0] mplier_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// add the shifted multiplicand where the current bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= {{NW{1'b0}}, a};
			mplier_q <= b;
		end else if (cnt_q != '0) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[NW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q[TB-1:0];
	// anything at or above bit 63 passes the positive range
	assign sat     = acc_q[PW-1:TB-1] != '0;
endmodule

/* rtl/core/divisor_power_sum.sv */
// Top level of the divisor power sum block: sequencer and result register.
// Usage: an operand word (number, exponent) enters on the operand channel and
// one result word (total, invalid, overflow) leaves on the result channel,
// both valid/ready. The block works on one word at a time: operand.ready is
// high only while the sequencer is idle, a finished result may still wait in
// the output register meanwhile.
// Sequence: an invalid word (number zero or negative exponent) goes straight
// to the output. Otherwise each candidate divisor d = 1, 2, ... is tested by
// the bit-serial division, until d exceeds number/d. Each divisor found adds,
// per member of its pair, k bit-serial multiplies plus the ST_POW and ST_ADD
// steps that close the power and add it to the sum; the serial divider and
// multiplier set the run time. Saturation ends the word early.
// Reset clears the sequencer and the result valid; no state passes between
// words. When the receiver stalls the result is held and no new result is
// written over it.
module divisor_power_sum #(
	parameter int NUMBER_WIDTH = dps_pkg::NUMBER_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dps_op_if.sink    operand,
	dps_res_if.source result
);
	localparam int NW = NUMBER_WIDTH;
	localparam int TB = dps_pkg::TOTAL_BITS;
	localparam int KB = dps_pkg::COUNT_BITS;

	dps_pkg::state_t state_q, state_d;

	logic [NW+dps_pkg::NUMBER_BITS-1:0] num_ext;
	logic [NW-1:0] n_q, d_q, q_q, base_q;
	logic [KB-1:0] e_q, cnt_q;
	logic [TB-1:0] r_q, sum_q;
	logic [TB-1:0] sum_next;
	logic          sat_q, inv_q, phase_q;
	logic          in_acc, in_bad, out_load;
	logic          div_start, div_done, mul_start, mul_done, mul_sat;
	logic [NW-1:0] div_quo, div_rem;
	logic [TB-1:0] mul_p;

	logic          out_valid_q;
	logic [TB-1:0] out_total_q;
	logic          out_inv_q, out_ovf_q;

	assign num_ext  = {{NW{1'b0}}, operand.number};
	assign in_acc   = operand.valid && operand.ready;
	assign in_bad   = (num_ext[NW-1:0] == '0) || operand.exponent[dps_pkg::EXPONENT_BITS-1];
	assign sum_next = sum_q + r_q;

	dps_divider #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(n_q), .divisor(d_q),
		.done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	dps_multiplier #(.NW(NW)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(r_q), .b(base_q),
		.done(mul_done), .product(mul_p), .sat(mul_sat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dps_pkg::ST_IDLE: begin
				if (in_acc) state_d = in_bad ? dps_pkg::ST_OUT : dps_pkg::ST_DIV_GO;
			end
			dps_pkg::ST_DIV_GO: state_d = dps_pkg::ST_DIV_WAIT;
			dps_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					if (div_quo < d_q) state_d = dps_pkg::ST_OUT;
					else if (div_rem != '0) state_d = dps_pkg::ST_DIV_GO;
					else state_d = dps_pkg::ST_POW;
				end
			end
			dps_pkg::ST_POW: begin
				state_d = (cnt_q == '0) ? dps_pkg::ST_ADD : dps_pkg::ST_MUL_WAIT;
			end
			dps_pkg::ST_MUL_WAIT: begin
				if (mul_done) state_d = mul_sat ? dps_pkg::ST_OUT : dps_pkg::ST_POW;
			end
			dps_pkg::ST_ADD: begin
				if (sum_next[TB-1]) state_d = dps_pkg::ST_OUT;
				else if (!phase_q && q_q != d_q) state_d = dps_pkg::ST_POW;
				else state_d = dps_pkg::ST_DIV_GO;
			end
			dps_pkg::ST_OUT: begin
				if (out_load) state_d = dps_pkg::ST_IDLE;
			end
			default: state_d = dps_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		operand.ready = 1'b0;
		div_start     = 1'b0;
		mul_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			dps_pkg::ST_IDLE:   operand.ready = 1'b1;
			dps_pkg::ST_DIV_GO: div_start = 1'b1;
			dps_pkg::ST_POW:    mul_start = (cnt_q != '0);
			dps_pkg::ST_OUT:    out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dps_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			dps_pkg::ST_IDLE: begin
				if (in_acc) begin
					n_q   <= num_ext[NW-1:0];
					e_q   <= operand.exponent[KB-1:0];
					inv_q <= in_bad;
					d_q   <= NW'(1);
					sum_q <= '0;
					sat_q <= 1'b0;
				end
			end
			dps_pkg::ST_DIV_WAIT: begin
				if (div_done && div_quo >= d_q) begin
					if (div_rem != '0) begin
						d_q <= d_q + 1'b1;
					end else begin
						q_q     <= div_quo;
						base_q  <= d_q;
						phase_q <= 1'b0;
						r_q     <= TB'(1);
						cnt_q   <= e_q;
					end
				end
			end
			dps_pkg::ST_MUL_WAIT: begin
				if (mul_done) begin
					if (mul_sat) sat_q <= 1'b1;
					r_q   <= mul_p;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			dps_pkg::ST_ADD: begin
				if (sum_next[TB-1]) begin
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_next;
					if (!phase_q && q_q != d_q) begin
						base_q  <= q_q;
						phase_q <= 1'b1;
						r_q     <= TB'(1);
						cnt_q   <= e_q;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_total_q <= inv_q ? '1 : (sat_q ? dps_pkg::SUM_MAX : sum_q);
			out_inv_q   <= inv_q;
			out_ovf_q   <= !inv_q && sat_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.total    = out_total_q;
	assign result.invalid  = out_inv_q;
	assign result.overflow = out_ovf_q;
endmodule
